// ===== sv/gcev_pkg.sv =====
// Shared types and constants of the gamepad change event generator.
// No dependencies.
package gcev_pkg;

    typedef logic [1:0]         t_pad;
    typedef logic signed [15:0] t_axis;
    typedef logic [7:0]         t_trig;
    typedef logic [15:0]        t_word;
    typedef logic [1:0]         t_kind;
    typedef logic [3:0]         t_which;
    typedef logic [1:0]         t_dir;
    typedef logic [1:0]         t_reg_idx;
    typedef logic [15:0]        t_reg_data;

    localparam t_kind KIND_AXIS = 2'd0;
    localparam t_kind KIND_TRIG = 2'd1;
    localparam t_kind KIND_BTN  = 2'd2;

    localparam t_dir DIR_CENTER = 2'd0;
    localparam t_dir DIR_POS    = 2'd1;
    localparam t_dir DIR_NEG    = 2'd2;
    localparam t_dir DIR_UP     = 2'd0;
    localparam t_dir DIR_DOWN   = 2'd1;

    localparam t_reg_idx REG_LEFT_DZ  = 2'd0;
    localparam t_reg_idx REG_RIGHT_DZ = 2'd1;
    localparam t_reg_idx REG_TRIG_THR = 2'd2;

    localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
    localparam logic [7:0]  TRIG_THR_RESET = 8'd30;

    localparam logic [14:0] AXIS_FULL = 15'h7fff;
    localparam logic [7:0]  TRIG_FULL = 8'hff;

    localparam int NUM_AXES    = 4;
    localparam int NUM_TRIGS   = 2;
    localparam int NUM_BUTTONS = 14;
    localparam int NUM_EVENTS  = NUM_AXES + NUM_TRIGS + NUM_BUTTONS;
    localparam int QUO_W       = 31;
    localparam int DEN_W       = 16;

endpackage

// ===== sv/gcev_if.sv =====
// Handshake channels of the gamepad change event generator: snapshot in,
// event out, register write. Depends on gcev_pkg.
interface gcev_in_if import gcev_pkg::*; ();
    logic  valid;
    logic  ready;
    t_pad  pad;
    t_axis left_x;
    t_axis left_y;
    t_axis right_x;
    t_axis right_y;
    t_trig left_trigger;
    t_trig right_trigger;
    t_word button_word;

    modport source (output valid, pad, left_x, left_y, right_x, right_y,
                    left_trigger, right_trigger, button_word, input ready);
    modport sink   (input valid, pad, left_x, left_y, right_x, right_y,
                    left_trigger, right_trigger, button_word, output ready);
endinterface

interface gcev_out_if import gcev_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pad   pad_id;
    t_kind  kind;
    t_which which;
    t_axis  value;
    t_dir   direction;
    logic   last;

    modport source (output valid, pad_id, kind, which, value, direction, last,
                    input ready);
    modport sink   (input valid, pad_id, kind, which, value, direction, last,
                    output ready);
endinterface

interface gcev_cfg_if import gcev_pkg::*; ();
    logic      valid;
    logic      ready;
    t_reg_idx  index;
    t_reg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/gamepad_change_event_generator.sv =====
// Gamepad change event generator: per-pad snapshot compare, one shared
// restoring divider for axis and trigger rescaling. Depends on gcev_pkg, gcev_if.
// Flow: a snapshot is registered in ST_IDLE, compared and stored in ST_LOAD, then
// scanned slot by slot; a button event goes from its scan step to ST_OUT, a rescaled
// axis or trigger event through ST_DIV (31 divider steps) and ST_FIN. The next snapshot
// is taken only after the 20-slot scan ends, so divisions and output stalls hold it off.
// Reset clears the registers to their defaults and all stored snapshots to zero.
module gamepad_change_event_generator import gcev_pkg::*; #(
    parameter int PAD_COUNT = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gcev_in_if.sink      i_in,
    gcev_out_if.source   o_out,
    gcev_cfg_if.sink     i_cfg
);

    localparam int PW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  r_state;
    logic [14:0] r_ldz;
    logic [14:0] r_rdz;
    logic [7:0]  r_thr;

    logic [15:0] r_prev_axes [PAD_COUNT][NUM_AXES];
    logic [7:0]  r_prev_trig [PAD_COUNT][NUM_TRIGS];
    logic [13:0] r_prev_btn  [PAD_COUNT];

    t_pad        r_pad;
    logic [PW-1:0] r_idx;
    logic [15:0] r_axis [NUM_AXES];
    logic [7:0]  r_trig [NUM_TRIGS];
    logic [13:0] r_bits;
    logic [NUM_TRIGS-1:0] r_tdown;
    logic [NUM_EVENTS-1:0] r_mask;
    logic [4:0]  r_pos;

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_neg;

    t_kind       r_kind;
    t_which      r_which;
    logic [15:0] r_val;
    t_dir        r_dir;

    logic [15:0] w_raw;
    logic [14:0] w_dz;
    logic signed [16:0] w_raw_s;
    logic signed [16:0] w_dz_s;
    logic [16:0] w_mag;
    logic [16:0] w_diff;
    logic [31:0] w_anum;
    logic [15:0] w_aden;
    logic        w_abelow;
    t_dir        w_adir;
    logic        w_tsel;
    logic [7:0]  w_t;
    logic [7:0]  w_tdiff;
    logic [15:0] w_tnum;
    logic [15:0] w_tden;
    logic [4:0]  w_bpos;
    logic [3:0]  w_bidx;
    logic [16:0] w_shift;
    logic        w_ge;
    logic [NUM_EVENTS-1:0] w_rest;
    logic [13:0] w_in_bits;
    logic [13:0] w_prev_bits;

    assign w_raw    = r_axis[r_pos[1:0]];
    assign w_dz     = r_pos[1] ? r_rdz : r_ldz;
    assign w_raw_s  = {w_raw[15], w_raw};
    assign w_dz_s   = {2'b00, w_dz};
    assign w_mag    = w_raw[15] ? 17'(-w_raw_s) : 17'(w_raw_s);
    assign w_abelow = w_mag < {2'b00, w_dz};
    assign w_diff   = w_mag - {2'b00, w_dz};
    assign w_anum   = (32'(w_diff) << 15) - 32'(w_diff);
    assign w_aden   = 16'd32767 - {1'b0, w_dz};

    always_comb begin
        if (w_raw_s >= w_dz_s) begin
            w_adir = DIR_POS;
        end else if (w_raw_s <= -w_dz_s) begin
            w_adir = DIR_NEG;
        end else begin
            w_adir = DIR_CENTER;
        end
    end

    assign w_tsel  = (r_pos == 5'd5);
    assign w_t     = r_trig[w_tsel];
    assign w_tdiff = w_t - r_thr;
    assign w_tnum  = (16'(w_tdiff) << 8) - 16'(w_tdiff);
    assign w_tden  = 16'(TRIG_FULL - r_thr);

    assign w_bpos = (r_pos >= 5'd6) ? (r_pos - 5'd6) : 5'd0;
    assign w_bidx = w_bpos[3:0];

    assign w_shift = {r_rem, r_quo[QUO_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};

    assign w_rest = r_mask >> r_pos;

    assign w_in_bits   = r_bits;
    assign w_prev_bits = r_prev_btn[r_idx];

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid     = (r_state == ST_OUT);
    assign o_out.pad_id    = r_pad;
    assign o_out.kind      = r_kind;
    assign o_out.which     = r_which;
    assign o_out.value     = r_val;
    assign o_out.direction = r_dir;
    assign o_out.last      = ~|w_rest[NUM_EVENTS-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ldz   <= LEFT_DZ_RESET;
            r_rdz   <= RIGHT_DZ_RESET;
            r_thr   <= TRIG_THR_RESET;
            for (int p = 0; p < PAD_COUNT; p++) begin
                for (int k = 0; k < NUM_AXES; k++) begin
                    r_prev_axes[p][k] <= '0;
                end
                for (int k = 0; k < NUM_TRIGS; k++) begin
                    r_prev_trig[p][k] <= '0;
                end
                r_prev_btn[p] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_LEFT_DZ:  r_ldz <= i_cfg.data[14:0];
                    REG_RIGHT_DZ: r_rdz <= i_cfg.data[14:0];
                    REG_TRIG_THR: r_thr <= i_cfg.data[7:0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_pad     <= i_in.pad;
                        r_idx     <= PW'({{PW{1'b0}}, i_in.pad});
                        r_axis[0] <= i_in.left_x;
                        r_axis[1] <= i_in.left_y;
                        r_axis[2] <= i_in.right_x;
                        r_axis[3] <= i_in.right_y;
                        r_trig[0] <= i_in.left_trigger;
                        r_trig[1] <= i_in.right_trigger;
                        r_bits    <= {i_in.button_word[15:12], i_in.button_word[9:0]};
                        if (32'(i_in.pad) < PAD_COUNT) begin
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    for (int k = 0; k < NUM_AXES; k++) begin
                        r_mask[k] <= r_axis[k] != r_prev_axes[r_idx][k];
                        r_prev_axes[r_idx][k] <= r_axis[k];
                    end
                    for (int k = 0; k < NUM_TRIGS; k++) begin
                        r_mask[NUM_AXES+k] <= (r_trig[k] < r_prev_trig[r_idx][k]) ||
                            ((r_trig[k] >= r_thr) && (r_trig[k] > r_prev_trig[r_idx][k]));
                        r_tdown[k] <= !(r_trig[k] < r_prev_trig[r_idx][k]);
                        r_prev_trig[r_idx][k] <= r_trig[k];
                    end
                    r_mask[NUM_EVENTS-1:NUM_AXES+NUM_TRIGS] <= w_in_bits ^ w_prev_bits;
                    r_prev_btn[r_idx] <= w_in_bits;
                    r_pos   <= '0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_pos == 5'(NUM_EVENTS)) begin
                        r_state <= ST_IDLE;
                    end else if (!r_mask[r_pos]) begin
                        r_pos <= r_pos + 5'd1;
                    end else if (r_pos < 5'(NUM_AXES)) begin
                        r_kind  <= KIND_AXIS;
                        r_which <= 4'(r_pos);
                        r_dir   <= w_adir;
                        r_neg   <= w_raw[15];
                        if (w_abelow) begin
                            r_val   <= '0;
                            r_state <= ST_OUT;
                        end else if (w_dz == AXIS_FULL) begin
                            r_val   <= w_raw;
                            r_state <= ST_OUT;
                        end else begin
                            r_quo   <= w_anum[QUO_W-1:0];
                            r_den   <= w_aden;
                            r_rem   <= '0;
                            r_cnt   <= 5'(QUO_W);
                            r_state <= ST_DIV;
                        end
                    end else if (r_pos < 5'(NUM_AXES + NUM_TRIGS)) begin
                        r_kind  <= KIND_TRIG;
                        r_which <= {3'd0, w_tsel};
                        r_dir   <= r_tdown[w_tsel] ? DIR_DOWN : DIR_UP;
                        r_neg   <= 1'b0;
                        if (w_t < r_thr) begin
                            r_val   <= '0;
                            r_state <= ST_OUT;
                        end else if (r_thr == TRIG_FULL) begin
                            r_val   <= 16'(TRIG_FULL);
                            r_state <= ST_OUT;
                        end else begin
                            r_quo   <= QUO_W'(w_tnum);
                            r_den   <= w_tden;
                            r_rem   <= '0;
                            r_cnt   <= 5'(QUO_W);
                            r_state <= ST_DIV;
                        end
                    end else begin
                        r_kind  <= KIND_BTN;
                        r_which <= w_bidx;
                        r_val   <= '0;
                        r_dir   <= r_bits[w_bidx] ? DIR_DOWN : DIR_UP;
                        r_state <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    r_rem <= w_ge ? DEN_W'(w_shift - {1'b0, r_den}) : w_shift[DEN_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], w_ge};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (r_neg) begin
                        r_val <= (r_quo > QUO_W'(32768)) ? 16'h8000 : 16'(-r_quo[15:0]);
                    end else begin
                        r_val <= (r_quo > QUO_W'(32767)) ? 16'h7fff : r_quo[15:0];
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (o_out.ready) begin
                        r_pos   <= r_pos + 5'd1;
                        r_state <= ST_SCAN;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/gcev_checker.sv =====
// Port-level checks of the gamepad change event generator and their bind.
// Depends on gcev_pkg and the top level.
module gcev_checker import gcev_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input t_kind       i_out_kind,
    input t_which      i_out_which,
    input logic [15:0] i_out_value,
    input logic        i_out_last
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("snapshot taken while an event is pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_kind) && $stable(i_out_which))
        else $error("stalled event changed");

    a_btn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_BTN |-> i_out_value == 16'd0)
        else $error("button event with nonzero value");

    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_TRIG |->
            i_out_value[15:8] == 8'd0 && i_out_which < 4'd2)
        else $error("trigger event out of range");

    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> !i_in_ready)
        else $error("snapshot accepted before its last event");

endmodule

bind gamepad_change_event_generator gcev_checker u_gcev_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_which (o_out.which),
    .i_out_value (o_out.value),
    .i_out_last  (o_out.last)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the gamepad change event generator: directed table, then
// randomized snapshots under several register settings. Depends on gcev_pkg, gcev_if.
module tb_top;
    import gcev_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 10;
    localparam int PADS             = 4;
    localparam int SETTLE_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 35;
    localparam t_reg_idx REG_SPARE  = 2'd3;

    typedef struct {
        t_pad  pad;
        t_axis axis [NUM_AXES];
        t_trig trig [NUM_TRIGS];
        t_word buttons;
    } t_snap;

    typedef struct {
        t_pad   pad_id;
        t_kind  kind;
        t_which which;
        t_axis  value;
        t_dir   direction;
        logic   last;
    } t_ev;

    typedef t_ev t_ev_q[$];

    typedef struct {
        bit          is_cfg;
        t_snap       snap;
        logic [14:0] ldz;
        logic [14:0] rdz;
        t_trig       thr;
        int          hand_n;
        t_ev         hand_ev;
    } t_row;

    typedef struct packed {
        logic [14:0] ldz;
        logic [14:0] rdz;
        t_trig       thr;
        int          idle_pct;
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gcev_in_if  snap_if ();
    gcev_out_if ev_if ();
    gcev_cfg_if cfg_if ();

    gamepad_change_event_generator #(.PAD_COUNT(PADS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (snap_if),
        .o_out   (ev_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    logic [14:0] left_dz;
    logic [14:0] right_dz;
    t_trig       trig_thr;
    t_axis       stored_axes [PADS][NUM_AXES];
    t_trig       stored_trig [PADS][NUM_TRIGS];
    logic [13:0] stored_btn [PADS];

    t_ev  pending_events[$];
    t_ev  want_ev;
    int   errors = 0;
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    t_row directed[$];
    t_phase phases[$];

    function automatic t_snap mk_snap(int p, int lx, int ly, int rx, int ry,
                                      int lt, int rt, int bw);
        t_snap s;
        s.pad     = t_pad'(p);
        s.axis[0] = t_axis'(lx);
        s.axis[1] = t_axis'(ly);
        s.axis[2] = t_axis'(rx);
        s.axis[3] = t_axis'(ry);
        s.trig[0] = t_trig'(lt);
        s.trig[1] = t_trig'(rt);
        s.buttons = t_word'(bw);
        return s;
    endfunction

    function automatic t_ev mk_event(int p, t_kind k, int w, int v, t_dir d, bit l);
        t_ev e;
        e.pad_id    = t_pad'(p);
        e.kind      = k;
        e.which     = t_which'(w);
        e.value     = t_axis'(v);
        e.direction = d;
        e.last      = l;
        return e;
    endfunction

    function automatic t_row pred_row(t_snap s);
        t_row r;
        r.is_cfg = 1'b0;
        r.snap   = s;
        r.hand_n = -1;
        return r;
    endfunction

    function automatic t_row quiet_row(t_snap s);
        t_row r;
        r.is_cfg = 1'b0;
        r.snap   = s;
        r.hand_n = 0;
        return r;
    endfunction

    function automatic t_row hand_row(t_snap s, t_ev e);
        t_row r;
        r.is_cfg  = 1'b0;
        r.snap    = s;
        r.hand_n  = 1;
        r.hand_ev = e;
        return r;
    endfunction

    function automatic t_row cfg_row(int l, int r, int t);
        t_row c;
        c.is_cfg = 1'b1;
        c.ldz    = 15'(l);
        c.rdz    = 15'(r);
        c.thr    = t_trig'(t);
        c.hand_n = 0;
        return c;
    endfunction

    function automatic int scale_axis(int raw, int dz);
        int     mag;
        longint q;
        mag = (raw < 0) ? -raw : raw;
        if (mag < dz)
            return 0;
        if (dz >= int'(AXIS_FULL))
            return raw;
        q = (longint'(mag - dz) * int'(AXIS_FULL)) / longint'(int'(AXIS_FULL) - dz);
        if (raw < 0)
            q = -q;
        if (q < -32768)
            q = -32768;
        if (q > 32767)
            q = 32767;
        return int'(q);
    endfunction

    function automatic int scale_trig(int t, int thr);
        if (t < thr)
            return 0;
        if (thr >= int'(TRIG_FULL))
            return int'(TRIG_FULL);
        return ((t - thr) * int'(TRIG_FULL)) / (int'(TRIG_FULL) - thr);
    endfunction

    // Compare against the stored snapshot of the pad, then store the new one.
    function automatic t_ev_q derive_events(t_snap s);
        t_ev_q       evs;
        t_ev         e;
        int          k;
        int          raw;
        int          dz;
        int          cur;
        int          prv;
        int          thr;
        t_dir        dir;
        logic [13:0] bits;
        if (int'(s.pad) >= PADS)
            return evs;
        for (k = 0; k < NUM_AXES; k++) begin
            raw = s.axis[k];
            dz  = (k < 2) ? int'(left_dz) : int'(right_dz);
            if (s.axis[k] != stored_axes[s.pad][k]) begin
                if (raw >= dz)
                    dir = DIR_POS;
                else if (raw <= -dz)
                    dir = DIR_NEG;
                else
                    dir = DIR_CENTER;
                evs = {evs, mk_event(s.pad, KIND_AXIS, k, scale_axis(raw, dz), dir,
                                     1'b0)};
            end
            stored_axes[s.pad][k] = s.axis[k];
        end
        thr = int'(trig_thr);
        for (k = 0; k < NUM_TRIGS; k++) begin
            cur = int'(s.trig[k]);
            prv = int'(stored_trig[s.pad][k]);
            if (cur < prv)
                evs = {evs, mk_event(s.pad, KIND_TRIG, k, scale_trig(cur, thr), DIR_UP,
                                     1'b0)};
            else if (cur >= thr && cur > prv)
                evs = {evs, mk_event(s.pad, KIND_TRIG, k, scale_trig(cur, thr), DIR_DOWN,
                                     1'b0)};
            stored_trig[s.pad][k] = s.trig[k];
        end
        bits = {s.buttons[15:12], s.buttons[9:0]};
        for (k = 0; k < NUM_BUTTONS; k++) begin
            if (bits[k] != stored_btn[s.pad][k])
                evs = {evs, mk_event(s.pad, KIND_BTN, k, 0,
                                     bits[k] ? DIR_DOWN : DIR_UP, 1'b0)};
        end
        stored_btn[s.pad] = bits;
        if (evs.size() > 0) begin
            e = evs[evs.size() - 1];
            e.last = 1'b1;
            evs[evs.size() - 1] = e;
        end
        return evs;
    endfunction

    // Values kept from the stored snapshot, small axis moves, hits around the deadzones
    // and threshold, the extremes, and some fully random values.
    function automatic t_snap random_snapshot();
        t_snap s;
        t_pad  p;
        int    k;
        int    v;
        int    dz;
        p = t_pad'($urandom_range(0, PADS - 1));
        s.pad = p;
        for (k = 0; k < NUM_AXES; k++) begin
            dz = (k < 2) ? int'(left_dz) : int'(right_dz);
            v  = stored_axes[p][k];
            case ($urandom_range(0, 9))
                4, 5: v = int'($urandom_range(0, 65535)) - 32768;
                6, 7: begin
                    v = dz + int'($urandom_range(0, 4)) - 2;
                    if ($urandom_range(0, 1) != 0)
                        v = -v;
                end
                8: begin
                    case ($urandom_range(0, 3))
                        0: v = -32768;
                        1: v = -32767;
                        2: v = 0;
                        default: v = 32767;
                    endcase
                end
                9: v = v + (($urandom_range(0, 1) != 0) ? 1 : -1);
                default: ;
            endcase
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            s.axis[k] = t_axis'(v);
        end
        for (k = 0; k < NUM_TRIGS; k++) begin
            v = stored_trig[p][k];
            case ($urandom_range(0, 9))
                4, 5, 6: v = int'($urandom_range(0, 255));
                7, 8:    v = int'(trig_thr) + int'($urandom_range(0, 4)) - 2;
                9:       v = ($urandom_range(0, 1) != 0) ? 255 : 0;
                default: ;
            endcase
            if (v > 255)
                v = 255;
            if (v < 0)
                v = 0;
            s.trig[k] = t_trig'(v);
        end
        s.buttons = {stored_btn[p][13:10], 2'($urandom_range(0, 3)), stored_btn[p][9:0]};
        case ($urandom_range(0, 9))
            4, 5, 6, 7: begin
                repeat ($urandom_range(1, 3))
                    s.buttons = s.buttons ^ (16'd1 << $urandom_range(0, 15));
            end
            8, 9: s.buttons = t_word'($urandom_range(0, 65535));
            default: ;
        endcase
        return s;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void add_row(t_row r);
        directed = {directed, r};
    endfunction

    function automatic void add_phase(t_phase ph);
        phases = {phases, ph};
    endfunction

    task automatic drain_and_settle();
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, t_reg_data d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_LEFT_DZ:  left_dz  = d[14:0];
            REG_RIGHT_DZ: right_dz = d[14:0];
            REG_TRIG_THR: trig_thr = d[7:0];
            default: ;
        endcase
    endtask

    // Unused data bits carry random values; the registers must drop them.
    task automatic write_settings(logic [14:0] ldz, logic [14:0] rdz, t_trig thr);
        snap_if.valid <= 1'b0;
        drain_and_settle();
        write_reg(REG_LEFT_DZ, t_reg_data'({1'($urandom_range(0, 1)), ldz}));
        write_reg(REG_RIGHT_DZ, t_reg_data'({1'($urandom_range(0, 1)), rdz}));
        write_reg(REG_TRIG_THR, t_reg_data'({8'($urandom_range(0, 255)), thr}));
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_SPARE, t_reg_data'($urandom_range(0, 65535)));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_snapshot(t_row r);
        t_ev_q evs;
        if ($urandom_range(0, 99) < gap_pct) begin
            snap_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        snap_if.valid         <= 1'b1;
        snap_if.pad           <= r.snap.pad;
        snap_if.left_x        <= r.snap.axis[0];
        snap_if.left_y        <= r.snap.axis[1];
        snap_if.right_x       <= r.snap.axis[2];
        snap_if.right_y       <= r.snap.axis[3];
        snap_if.left_trigger  <= r.snap.trig[0];
        snap_if.right_trigger <= r.snap.trig[1];
        snap_if.button_word   <= r.snap.buttons;
        do @(posedge i_clk); while (!snap_if.ready);
        evs = derive_events(r.snap);
        if (r.hand_n >= 0) begin
            evs.delete();
            if (r.hand_n > 0)
                evs = {evs, r.hand_ev};
        end
        pending_events = {pending_events, evs};
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            ev_if.ready <= 1'b0;
            stall_left  <= $urandom_range(0, 5);
        end else begin
            ev_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ev_if.valid && ev_if.ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: pad %0d kind %0d which %0d value %0d",
                       ev_if.pad_id, ev_if.kind, ev_if.which, ev_if.value);
                errors++;
            end else begin
                want_ev = pending_events.pop_front();
                check_field("pad_id", want_ev.pad_id, ev_if.pad_id);
                check_field("kind", want_ev.kind, ev_if.kind);
                check_field("which", want_ev.which, ev_if.which);
                check_field("value", $signed(want_ev.value), $signed(ev_if.value));
                check_field("direction", want_ev.direction, ev_if.direction);
                check_field("last", want_ev.last, ev_if.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((snap_if.valid && snap_if.ready) || (ev_if.valid && ev_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_phase ph;
        int     p;
        int     k;
        i_rst_n               = 1'b0;
        snap_if.valid         = 1'b0;
        snap_if.pad           = '0;
        snap_if.left_x        = '0;
        snap_if.left_y        = '0;
        snap_if.right_x       = '0;
        snap_if.right_y       = '0;
        snap_if.left_trigger  = '0;
        snap_if.right_trigger = '0;
        snap_if.button_word   = '0;
        ev_if.ready           = 1'b1;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = REG_LEFT_DZ;
        cfg_if.data           = '0;

        left_dz  = LEFT_DZ_RESET;
        right_dz = RIGHT_DZ_RESET;
        trig_thr = TRIG_THR_RESET;
        for (p = 0; p < PADS; p++) begin
            for (k = 0; k < NUM_AXES; k++)
                stored_axes[p][k] = '0;
            for (k = 0; k < NUM_TRIGS; k++)
                stored_trig[p][k] = '0;
            stored_btn[p] = '0;
        end

        add_row(quiet_row(mk_snap(0, 0, 0, 0, 0, 0, 0, 16'h0000)));
        add_row(hand_row(mk_snap(0, 0, 0, 0, 0, 0, 0, 16'h2000),
                         mk_event(0, KIND_BTN, 11, 0, DIR_DOWN, 1'b1)));
        add_row(hand_row(mk_snap(0, 0, 0, 0, 0, 0, 0, 16'h0c00),
                         mk_event(0, KIND_BTN, 11, 0, DIR_UP, 1'b1)));
        add_row(hand_row(mk_snap(1, 32767, 0, 0, 0, 0, 0, 0),
                         mk_event(1, KIND_AXIS, 0, 32767, DIR_POS, 1'b1)));
        add_row(hand_row(mk_snap(1, -32768, 0, 0, 0, 0, 0, 0),
                         mk_event(1, KIND_AXIS, 0, -32768, DIR_NEG, 1'b1)));
        add_row(hand_row(mk_snap(2, 0, 0, 0, 0, 255, 0, 0),
                         mk_event(2, KIND_TRIG, 0, 255, DIR_DOWN, 1'b1)));
        add_row(hand_row(mk_snap(2, 0, 0, 0, 0, 29, 0, 0),
                         mk_event(2, KIND_TRIG, 0, 0, DIR_UP, 1'b1)));
        add_row(hand_row(mk_snap(2, 0, 0, 0, 0, 30, 0, 0),
                         mk_event(2, KIND_TRIG, 0, 0, DIR_DOWN, 1'b1)));
        add_row(quiet_row(mk_snap(3, 0, 0, 0, 0, 0, 10, 0)));
        add_row(pred_row(mk_snap(3, 1000, -9000, 8689, -8689, 200, 5, 16'hffff)));
        add_row(pred_row(mk_snap(3, 0, 0, 0, 0, 0, 0, 16'h0000)));
        add_row(pred_row(mk_snap(0, 0, 0, 0, 0, 0, 0, 16'hf3ff)));
        add_row(pred_row(mk_snap(2, -20000, 20000, -1, 1, 100, 255, 16'h5a5a)));
        add_row(cfg_row(0, 32766, 0));
        add_row(hand_row(mk_snap(1, 0, 0, 0, 0, 0, 0, 0),
                         mk_event(1, KIND_AXIS, 0, 0, DIR_POS, 1'b1)));
        add_row(hand_row(mk_snap(1, 0, 0, -32768, 0, 0, 0, 0),
                         mk_event(1, KIND_AXIS, 2, -32768, DIR_NEG, 1'b1)));
        add_row(hand_row(mk_snap(1, 0, 0, 32767, 0, 0, 0, 0),
                         mk_event(1, KIND_AXIS, 2, 32767, DIR_POS, 1'b1)));
        add_row(hand_row(mk_snap(1, 0, 0, 32767, 0, 1, 0, 0),
                         mk_event(1, KIND_TRIG, 0, 1, DIR_DOWN, 1'b1)));
        add_row(cfg_row(32767, 32767, 255));
        add_row(hand_row(mk_snap(1, 32767, 0, 32767, 0, 1, 0, 0),
                         mk_event(1, KIND_AXIS, 0, 32767, DIR_POS, 1'b1)));
        add_row(hand_row(mk_snap(1, -32767, 0, 32767, 0, 1, 0, 0),
                         mk_event(1, KIND_AXIS, 0, -32767, DIR_NEG, 1'b1)));
        add_row(hand_row(mk_snap(1, -32768, 0, 32767, 0, 1, 0, 0),
                         mk_event(1, KIND_AXIS, 0, -32768, DIR_NEG, 1'b1)));
        add_row(hand_row(mk_snap(1, -32768, 0, 32767, 0, 255, 0, 0),
                         mk_event(1, KIND_TRIG, 0, 255, DIR_DOWN, 1'b1)));
        add_row(hand_row(mk_snap(1, -32768, 0, 32767, 0, 254, 0, 0),
                         mk_event(1, KIND_TRIG, 0, 0, DIR_UP, 1'b1)));
        add_row(hand_row(mk_snap(1, -32768, 100, 32767, 0, 254, 0, 0),
                         mk_event(1, KIND_AXIS, 1, 0, DIR_CENTER, 1'b1)));

        add_phase('{15'd0, 15'd0, 8'd0, 30});
        add_phase('{15'd32767, 15'd32767, 8'd255, 0});
        add_phase('{15'd32766, 15'd1, 8'd254, 50});
        add_phase('{15'd1, 15'd32766, 8'd1, 20});
        add_phase('{15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                    8'($urandom_range(0, 255)), 40});
        add_phase('{15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                    8'($urandom_range(0, 255)), 10});
        add_phase('{LEFT_DZ_RESET, RIGHT_DZ_RESET, TRIG_THR_RESET, 0});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 25;
        stall_pct = 25;
        foreach (directed[i]) begin
            if (directed[i].is_cfg)
                write_settings(directed[i].ldz, directed[i].rdz, directed[i].thr);
            else
                send_snapshot(directed[i]);
        end

        foreach (phases[i]) begin
            ph = phases[i];
            write_settings(ph.ldz, ph.rdz, ph.thr);
            gap_pct   = ph.idle_pct;
            stall_pct = ph.idle_pct;
            repeat (RANDOM_PER_PHASE)
                send_snapshot(pred_row(random_snapshot()));
        end

        snap_if.valid <= 1'b0;
        drain_and_settle();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
